>>> design/lcdnw_pkg.sv
// Shared types and constants for the character LCD nibble writer.
package lcdnw_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] value;
    logic       fast;
  } lcdnw_in_t;

  typedef struct packed {
    logic       enable_pin;
    logic       select_pin;
    logic [3:0] data_pins;
    logic       busy_res;
    logic       refused;
  } lcdnw_out_t;

  typedef enum logic [1:0] {
    FUNC_TICK       = 2'd0,
    FUNC_CMD_BYTE   = 2'd1,
    FUNC_DATA_BYTE  = 2'd2,
    FUNC_CMD_NIBBLE = 2'd3
  } lcdnw_func_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SETUP = 2'd1,
    PH_HIGH  = 2'd2,
    PH_LOW   = 2'd3
  } lcdnw_phase_t;

  typedef enum logic {
    CFG_SLOW_HOLD = 1'b0,
    CFG_FAST_HOLD = 1'b1
  } lcdnw_cfg_idx_t;

  // Classified item as it travels from the front end to the sequencer.
  typedef struct packed {
    logic       is_tick;
    logic       is_data;
    logic       has_second;
    logic       fast;
    logic [3:0] first_nib;
    logic [3:0] second_nib;
  } lcdnw_cmd_t;

  localparam logic [15:0] SLOW_HOLD_RESET = 16'd800;
  localparam logic [15:0] FAST_HOLD_RESET = 16'd30;

endpackage

>>> design/lcdnw_front.sv
// Front end: decodes an incoming beat into a classified command.
module lcdnw_front (
  input  lcdnw_pkg::lcdnw_in_t  in_item,
  output lcdnw_pkg::lcdnw_cmd_t cmd
);
  import lcdnw_pkg::*;

  always_comb begin
    cmd            = '0;
    cmd.fast       = in_item.fast;
    cmd.second_nib = in_item.value[3:0];
    unique case (lcdnw_func_t'(in_item.func))
      FUNC_TICK: begin
        cmd.is_tick = 1'b1;
      end
      FUNC_CMD_BYTE: begin
        cmd.has_second = 1'b1;
        cmd.first_nib  = in_item.value[7:4];
      end
      FUNC_DATA_BYTE: begin
        cmd.is_data    = 1'b1;
        cmd.has_second = 1'b1;
        cmd.first_nib  = in_item.value[7:4];
      end
      FUNC_CMD_NIBBLE: begin
        cmd.first_nib = in_item.value[3:0];
      end
      default: begin
        cmd.is_tick = 1'b1;
      end
    endcase
  end

endmodule

>>> design/lcdnw_cmd_queue.sv
// Short command queue between the front end and the sequencer.
module lcdnw_cmd_queue #(
  parameter int DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lcdnw_pkg::lcdnw_cmd_t push_cmd,
  output logic                  full,
  input  logic                  pop,
  output lcdnw_pkg::lcdnw_cmd_t pop_cmd,
  output logic                  empty
);
  import lcdnw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lcdnw_cmd_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/lcdnw_back.sv
// Back end: nibble sequencer with pin state, hold counter and result queue.
module lcdnw_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  lcdnw_pkg::lcdnw_cmd_t  cmd,
  output logic                   cmd_pop,
  input  logic [15:0]            slow_hold,
  input  logic [15:0]            fast_hold,
  output lcdnw_pkg::lcdnw_out_t  out_item,
  output logic                   out_empty,
  input  logic                   out_pop
);
  import lcdnw_pkg::*;

  lcdnw_phase_t phase_r, phase_nxt;
  logic [15:0]  wait_r, wait_nxt;
  logic [3:0]   latch_r, latch_nxt;
  logic         pending_r, pending_nxt;
  logic         fast_mode_r, fast_mode_nxt;
  logic         e_r, e_nxt;
  logic         rs_r, rs_nxt;
  logic [3:0]   data_r, data_nxt;

  logic         fire, req_ok, refuse, tick_end, busy;
  logic [15:0]  hold;

  // Two-entry result queue.
  lcdnw_out_t   res_mem_r [2];
  logic         res_wr_r, res_rd_r;
  logic [1:0]   res_cnt_r;
  logic         res_full, res_push, res_pop;
  lcdnw_out_t   res_new;

  assign res_full = (res_cnt_r == 2'd2);
  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign busy     = (phase_r != PH_IDLE);
  assign req_ok   = !cmd.is_tick && !busy;
  assign refuse   = !cmd.is_tick && busy;
  assign tick_end = cmd.is_tick && busy && (wait_r <= 16'd1);
  // A new request picks its hold length by its own timing select.
  assign hold     = (req_ok ? cmd.fast : fast_mode_r) ? fast_hold : slow_hold;

  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (req_ok) begin
        phase_nxt = cmd.fast ? PH_SETUP : PH_HIGH;
      end else if (tick_end) begin
        unique case (phase_r)
          PH_SETUP: phase_nxt = PH_HIGH;
          PH_HIGH:  phase_nxt = PH_LOW;
          PH_LOW:   phase_nxt = pending_r ? (fast_mode_r ? PH_SETUP : PH_HIGH) : PH_IDLE;
          default:  phase_nxt = PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    wait_nxt      = wait_r;
    latch_nxt     = latch_r;
    pending_nxt   = pending_r;
    fast_mode_nxt = fast_mode_r;
    e_nxt         = e_r;
    rs_nxt        = rs_r;
    data_nxt      = data_r;
    if (fire) begin
      if (req_ok) begin
        fast_mode_nxt = cmd.fast;
        rs_nxt        = !cmd.is_data;
        pending_nxt   = cmd.has_second;
        latch_nxt     = cmd.second_nib;
        data_nxt      = ~cmd.first_nib;
        wait_nxt      = hold;
        e_nxt         = !cmd.fast;
      end else if (tick_end) begin
        unique case (phase_r)
          PH_SETUP: begin
            e_nxt    = 1'b1;
            wait_nxt = hold;
          end
          PH_HIGH: begin
            e_nxt    = 1'b0;
            wait_nxt = hold;
          end
          PH_LOW: begin
            if (pending_r) begin
              pending_nxt = 1'b0;
              data_nxt    = ~latch_r;
              wait_nxt    = hold;
              e_nxt       = !fast_mode_r;
            end else begin
              wait_nxt = '0;
            end
          end
          default: begin
            wait_nxt = '0;
          end
        endcase
      end else if (cmd.is_tick && busy) begin
        wait_nxt = wait_r - 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      wait_r      <= '0;
      latch_r     <= '0;
      pending_r   <= 1'b0;
      fast_mode_r <= 1'b0;
      e_r         <= 1'b0;
      rs_r        <= 1'b1;
      data_r      <= '0;
    end else begin
      phase_r     <= phase_nxt;
      wait_r      <= wait_nxt;
      latch_r     <= latch_nxt;
      pending_r   <= pending_nxt;
      fast_mode_r <= fast_mode_nxt;
      e_r         <= e_nxt;
      rs_r        <= rs_nxt;
      data_r      <= data_nxt;
    end
  end

  always_comb begin
    res_new.enable_pin = e_nxt;
    res_new.select_pin = rs_nxt;
    res_new.data_pins  = data_nxt;
    res_new.busy_res   = (phase_nxt != PH_IDLE);
    res_new.refused    = refuse;
  end

  assign res_push  = fire;
  assign out_empty = (res_cnt_r == 2'd0);
  assign res_pop   = out_pop && !out_empty;
  assign out_item  = res_mem_r[res_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_wr_r  <= 1'b0;
      res_rd_r  <= 1'b0;
      res_cnt_r <= '0;
    end else begin
      if (res_push) begin
        res_wr_r <= ~res_wr_r;
      end
      if (res_pop) begin
        res_rd_r <= ~res_rd_r;
      end
      if (res_push && !res_pop) begin
        res_cnt_r <= res_cnt_r + 2'd1;
      end else if (res_pop && !res_push) begin
        res_cnt_r <= res_cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem_r[res_wr_r] <= res_new;
    end
  end

  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && res_new.refused |-> res_new.busy_res)
    else $error("refused result reported not busy");

  a_idle_strobe_low: assert property (@(posedge clk) disable iff (!rst_n)
    res_push && !res_new.busy_res |-> !res_new.enable_pin)
    else $error("strobe asserted while idle");

  a_idle_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> wait_r == 16'd0 && !pending_r)
    else $error("idle with wait count or pending nibble");

  a_refuse_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire && refuse |=> $stable(phase_r) && $stable(wait_r) && $stable(data_r))
    else $error("refused request changed state");

endmodule

>>> design/char_lcd_nibble_writer.sv
// An accepted item is registered in the command queue; the sequencer then pops it and
// writes its result beat into the result queue, which drives the outputs.
// Throughput: one item per cycle while the result queue is not full.
// Pin timing is counted in tick items, not clock cycles.
// Reset (rst_n low, synchronous): queues empty, idle, E low, RS command, data 0,
// hold registers 800 slow and 30 fast.
module char_lcd_nibble_writer #(
  parameter int CMD_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  input  lcdnw_pkg::lcdnw_in_t  in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  logic                  out_pop,
  output lcdnw_pkg::lcdnw_out_t out_item,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_wdata
);
  import lcdnw_pkg::*;

  logic [15:0] slow_hold_r;
  logic [15:0] fast_hold_r;
  lcdnw_cmd_t  front_cmd, q_cmd;
  logic        q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slow_hold_r <= SLOW_HOLD_RESET;
      fast_hold_r <= FAST_HOLD_RESET;
    end else if (cfg_we) begin
      unique case (lcdnw_cfg_idx_t'(cfg_index))
        CFG_SLOW_HOLD: slow_hold_r <= cfg_wdata;
        CFG_FAST_HOLD: fast_hold_r <= cfg_wdata;
        default:       slow_hold_r <= slow_hold_r;
      endcase
    end
  end

  lcdnw_front u_front (
    .in_item (in_item),
    .cmd     (front_cmd)
  );

  lcdnw_cmd_queue #(
    .DEPTH (CMD_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_push),
    .push_cmd (front_cmd),
    .full     (in_full),
    .pop      (q_pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  lcdnw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .slow_hold (slow_hold_r),
    .fast_hold (fast_hold_r),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule
